FILE: hdl/chdp_pkg.sv
package chdp_pkg;

   // Input beat: one message byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // Result beat: decoded header and status
   typedef struct packed {
      logic [31:0] seq_num;
      logic [7:0]  cmd_code;
      logic [5:0]  operation;
      logic        addressed;
      logic [47:0] zone_id;
      logic [1:0]  status;
   } rsp_type;

   // Status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_DUPLICATE  = 2'd1;
   localparam logic [1:0] STATUS_HDR_SHORT  = 2'd2;
   localparam logic [1:0] STATUS_ZONE_SHORT = 2'd3;

   // Byte positions within a message
   localparam logic [3:0] IDX_SEQ_FIRST  = 4'd2;
   localparam logic [3:0] IDX_SEQ_LAST   = 4'd5;
   localparam logic [3:0] IDX_CMD        = 4'd6;
   localparam logic [3:0] IDX_FLAGS      = 4'd7;
   localparam logic [3:0] IDX_ZONE_FIRST = 4'd8;
   localparam logic [3:0] IDX_ZONE_LAST  = 4'd13;
   localparam logic [3:0] IDX_MAX        = 4'd15;

   // Empty ring slot marker
   localparam logic [31:0] SEQ_EMPTY = 32'hffff_ffff;
   // Addressing flag position in the flags byte
   localparam int unsigned ADDR_BIT = 7;

   // Controller to datapath commands
   typedef struct packed {
      logic       shift_seq;
      logic       load_cmd;
      logic       load_flags;
      logic       shift_zone;
      logic       lookup;
      logic       clear;
      logic       load_rsp;
      logic       zone_keep;
      logic [1:0] status;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic hit;
      logic addr_bit;
   } dp_stat_type;

endpackage

FILE: hdl/command_header_dedup_parser_unit.sv
// Command header parser with sequence-number duplicate filter.
// Throughput: one message byte per cycle unless stalled; the ring lookup
// is RING_DEPTH parallel 32-bit comparators evaluated on message byte 5.
// Latency: the result beat is valid the cycle after the last byte is taken.
// Reset (synchronous): all ring slots read as empty (all ones), write slot,
// byte counter and header fields clear; no clearing pass is needed.
module command_header_dedup_parser_unit #(
   parameter int RING_DEPTH = 11
) (
   input  logic              clock,
   input  logic              reset,
   // byte stream in
   input  logic              req_valid,
   output logic              req_stall,
   input  chdp_pkg::req_type req_payload,
   // decoded result out
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output chdp_pkg::rsp_type rsp_payload
);

   chdp_pkg::dp_cmd_type  dp_cmd;
   chdp_pkg::dp_stat_type dp_stat;

   // Controller: byte position counter, duplicate flag, status priority,
   // and the output valid register. Input stalls only while a finished
   // result beat is held by a stalled consumer.
   chdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_last  (req_payload.last_byte),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   // Datapath: header field shift registers, seen-number ring with write
   // pointer, parallel compare, and the result payload register.
   chdp_dpath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_payload.data_byte),
      .dp_cmd      (dp_cmd),
      .dp_stat     (dp_stat),
      .rsp_payload (rsp_payload)
   );

   // A taken last byte always produces a result beat next cycle.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.last_byte) |=> rsp_valid)
      else $error("last byte taken without a result beat");

   // A held result must block new input so it cannot be overwritten.
   a_held_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input open while result beat is held");

   // Zone id is reported only for addressed messages.
   a_zone_only_addressed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.addressed) |-> (rsp_payload.zone_id == '0))
      else $error("zone id set on unaddressed message");

   // Short zone status implies the addressing flag was set.
   a_zone_short_addressed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status == chdp_pkg::STATUS_ZONE_SHORT))
      |-> rsp_payload.addressed)
      else $error("zone short status without addressing flag");

endmodule

FILE: hdl/chdp_ctrl.sv
module chdp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output chdp_pkg::dp_cmd_type dp_cmd,
   input  chdp_pkg::dp_stat_type dp_stat
);

   logic [3:0] idx_ff, idx_in;
   logic       dup_ff, dup_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       last_beat;
   logic       dup_now;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign last_beat = accept && req_last;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      dp_cmd            = '0;
      dp_cmd.shift_seq  = accept && (idx_ff >= chdp_pkg::IDX_SEQ_FIRST)
                          && (idx_ff <= chdp_pkg::IDX_SEQ_LAST);
      dp_cmd.load_cmd   = accept && (idx_ff == chdp_pkg::IDX_CMD);
      dp_cmd.load_flags = accept && (idx_ff == chdp_pkg::IDX_FLAGS);
      dp_cmd.shift_zone = accept && (idx_ff >= chdp_pkg::IDX_ZONE_FIRST)
                          && (idx_ff <= chdp_pkg::IDX_ZONE_LAST);
      dp_cmd.lookup     = accept && (idx_ff == chdp_pkg::IDX_SEQ_LAST);
      dp_cmd.clear      = last_beat;
      dp_cmd.load_rsp   = last_beat;
      dp_cmd.zone_keep  = dp_stat.addr_bit && (idx_ff >= chdp_pkg::IDX_ZONE_LAST);

      dup_now = dup_ff || (dp_cmd.lookup && dp_stat.hit);

      // priority: too short for a sequence number, duplicate, short header, short zone
      priority if (idx_ff < chdp_pkg::IDX_SEQ_LAST) begin
         dp_cmd.status = chdp_pkg::STATUS_HDR_SHORT;
      end else if (dup_now) begin
         dp_cmd.status = chdp_pkg::STATUS_DUPLICATE;
      end else if (idx_ff < chdp_pkg::IDX_FLAGS) begin
         dp_cmd.status = chdp_pkg::STATUS_HDR_SHORT;
      end else if (dp_stat.addr_bit && (idx_ff < chdp_pkg::IDX_ZONE_LAST)) begin
         dp_cmd.status = chdp_pkg::STATUS_ZONE_SHORT;
      end else begin
         dp_cmd.status = chdp_pkg::STATUS_OK;
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      dup_in       = dup_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         if (req_last) begin
            idx_in = '0;
            dup_in = 1'b0;
         end else begin
            dup_in = dup_now;
            if (idx_ff != chdp_pkg::IDX_MAX) begin
               idx_in = idx_ff + 4'd1;
            end
         end
      end
      if (last_beat) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/chdp_dpath.sv
module chdp_dpath #(
   parameter int RING_DEPTH = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            data_byte,
   input  chdp_pkg::dp_cmd_type  dp_cmd,
   output chdp_pkg::dp_stat_type dp_stat,
   output chdp_pkg::rsp_type     rsp_payload
);

   localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   logic [31:0]       seq_ff, seq_in, seq_new;
   logic [7:0]        cmd_ff, cmd_in, cmd_new;
   logic [7:0]        flags_ff, flags_in, flags_new;
   logic [47:0]       zone_ff, zone_in, zone_new;
   logic [31:0]       ring_ff [RING_DEPTH];
   logic [31:0]       ring_in [RING_DEPTH];
   logic [SLOT_W-1:0] slot_ff, slot_in, slot_nxt;
   logic              hit;
   chdp_pkg::rsp_type rsp_ff, rsp_in;

   // field capture, values including the current byte
   assign seq_new   = dp_cmd.shift_seq  ? {seq_ff[23:0], data_byte}  : seq_ff;
   assign cmd_new   = dp_cmd.load_cmd   ? data_byte                  : cmd_ff;
   assign flags_new = dp_cmd.load_flags ? data_byte                  : flags_ff;
   assign zone_new  = dp_cmd.shift_zone ? {zone_ff[39:0], data_byte} : zone_ff;

   assign seq_in   = dp_cmd.clear ? '0 : seq_new;
   assign cmd_in   = dp_cmd.clear ? '0 : cmd_new;
   assign flags_in = dp_cmd.clear ? '0 : flags_new;
   assign zone_in  = dp_cmd.clear ? '0 : zone_new;

   // parallel compare against every ring slot
   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         if (ring_ff[i] == seq_new) begin
            hit = 1'b1;
         end
      end
   end

   assign slot_nxt = (slot_ff == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);

   // miss: record the number, advance, mark the following slot empty
   always_comb begin
      ring_in = ring_ff;
      slot_in = slot_ff;
      if (dp_cmd.lookup && !hit) begin
         ring_in[slot_ff]  = seq_new;
         ring_in[slot_nxt] = chdp_pkg::SEQ_EMPTY;
         slot_in           = slot_nxt;
      end
   end

   assign dp_stat.hit      = hit;
   assign dp_stat.addr_bit = flags_new[chdp_pkg::ADDR_BIT];

   always_comb begin
      rsp_in                 = rsp_ff;
      if (dp_cmd.load_rsp) begin
         rsp_in.seq_num   = seq_new;
         rsp_in.cmd_code  = cmd_new;
         rsp_in.operation = flags_new[5:0];
         rsp_in.addressed = flags_new[chdp_pkg::ADDR_BIT];
         rsp_in.zone_id   = dp_cmd.zone_keep ? zone_new : '0;
         rsp_in.status    = dp_cmd.status;
      end
   end

   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= '0;
         cmd_ff   <= '0;
         flags_ff <= '0;
         zone_ff  <= '0;
         slot_ff  <= '0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= chdp_pkg::SEQ_EMPTY;
         end
      end else begin
         seq_ff   <= seq_in;
         cmd_ff   <= cmd_in;
         flags_ff <= flags_in;
         zone_ff  <= zone_in;
         slot_ff  <= slot_in;
         ring_ff  <= ring_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int RING_DEPTH     = 11;
   localparam int RANDOM_BEATS   = 800;
   // last stretch of the run goes without any idling on either side
   localparam int CALM_BEATS     = 100;
   localparam int WATCHDOG_LIMIT = 1000;
   // idle wait after the last result is checked, as margin
   localparam int DRAIN_CYCLES   = 10;

   typedef struct {
      chdp_pkg::req_type beat;
      bit                drain;   // hold this beat back until every result is in
   } pending_beat_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   chdp_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   chdp_pkg::rsp_type rsp_payload;

   pending_beat_type  pending_beats[$];
   chdp_pkg::rsp_type expected_headers[$];
   logic [31:0]       seq_history[$];

   int beats_total;
   int beats_accepted    = 0;
   int results_predicted = 0;
   int results_checked   = 0;
   int error_count       = 0;
   int status_tally[4]   = '{0, 0, 0, 0};
   int send_gap          = 0;
   int stall_gap         = 0;
   int idle_cycles       = 0;
   bit calm              = 1'b0;

   // Shadow of the parser: ring of seen sequence numbers plus the
   // per-message header capture.
   logic [31:0] ring_seen[16];
   int          ring_slot;
   logic [3:0]  msg_pos;
   logic [31:0] msg_seq;
   logic [7:0]  msg_cmd;
   logic [7:0]  msg_flags;
   logic [47:0] msg_zone;
   bit          msg_dup;

   command_header_dedup_parser_unit #(
      .RING_DEPTH(RING_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   function automatic void clear_header();
      msg_pos   = '0;
      msg_seq   = '0;
      msg_cmd   = '0;
      msg_flags = '0;
      msg_zone  = '0;
      msg_dup   = 1'b0;
   endfunction

   function automatic void reset_shadow();
      for (int i = 0; i < 16; i++) ring_seen[i] = chdp_pkg::SEQ_EMPTY;
      ring_slot = 0;
      clear_header();
   endfunction

   // Advance the shadow by one accepted byte; queue the expected header
   // when the byte closes the message.
   function automatic void track_header_byte(chdp_pkg::req_type beat);
      logic [3:0]        pos;
      int                msg_len;
      bit                hit;
      bit                addr;
      chdp_pkg::rsp_type hdr;
      pos = msg_pos;
      hit = 1'b0;
      if (pos >= chdp_pkg::IDX_SEQ_FIRST && pos <= chdp_pkg::IDX_SEQ_LAST)
         msg_seq = {msg_seq[23:0], beat.data_byte};
      else if (pos == chdp_pkg::IDX_CMD)
         msg_cmd = beat.data_byte;
      else if (pos == chdp_pkg::IDX_FLAGS)
         msg_flags = beat.data_byte;
      else if (pos >= chdp_pkg::IDX_ZONE_FIRST && pos <= chdp_pkg::IDX_ZONE_LAST)
         msg_zone = {msg_zone[39:0], beat.data_byte};

      // sequence number complete: search the ring, record on a miss
      if (pos == chdp_pkg::IDX_SEQ_LAST) begin
         for (int i = 0; i < RING_DEPTH; i++)
            if (ring_seen[i] == msg_seq) hit = 1'b1;
         if (hit) begin
            msg_dup = 1'b1;
         end else begin
            ring_seen[ring_slot] = msg_seq;
            ring_slot = (ring_slot + 1) % RING_DEPTH;
            // slot ahead is marked empty, so all ones always hits
            ring_seen[ring_slot] = chdp_pkg::SEQ_EMPTY;
         end
      end

      msg_len = int'(pos) + 1;
      if (pos != chdp_pkg::IDX_MAX) msg_pos = pos + 4'd1;
      if (!beat.last_byte) return;

      addr = msg_flags[chdp_pkg::ADDR_BIT];
      hdr.seq_num   = msg_seq;
      hdr.cmd_code  = msg_cmd;
      hdr.operation = msg_flags[5:0];
      hdr.addressed = addr;
      hdr.zone_id   = (addr && msg_len >= 14) ? msg_zone : '0;
      if (msg_len < 6)
         hdr.status = chdp_pkg::STATUS_HDR_SHORT;
      else if (msg_dup)
         hdr.status = chdp_pkg::STATUS_DUPLICATE;
      else if (msg_len < 8)
         hdr.status = chdp_pkg::STATUS_HDR_SHORT;
      else if (addr && msg_len < 14)
         hdr.status = chdp_pkg::STATUS_ZONE_SHORT;
      else
         hdr.status = chdp_pkg::STATUS_OK;
      expected_headers.insert(expected_headers.size(), hdr);
      results_predicted++;
      clear_header();
   endfunction

   // Lay out one message as byte beats; bytes 0, 1 and anything past the
   // zone id are filler.
   task automatic queue_message(logic [31:0] seq, logic [7:0] cmd, logic [7:0] flags,
                                logic [47:0] zone, int len, bit drain);
      pending_beat_type pb;
      for (int i = 0; i < len; i++) begin
         pb.beat.data_byte = 8'($urandom);
         if (i >= 2 && i <= 5)
            pb.beat.data_byte = seq[8*(5-i) +: 8];
         else if (i == 6)
            pb.beat.data_byte = cmd;
         else if (i == 7)
            pb.beat.data_byte = flags;
         else if (i >= 8 && i <= 13)
            pb.beat.data_byte = zone[8*(13-i) +: 8];
         pb.beat.last_byte = (i == len - 1);
         pb.drain = drain && (i == 0);
         pending_beats.insert(pending_beats.size(), pb);
      end
      seq_history.insert(seq_history.size(), seq);
      if (seq_history.size() > 16) void'(seq_history.pop_front());
   endtask

   task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h",
                  $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   // Driver: presents pending beats, inserts idle bursts, and holds a
   // stalled beat steady. Prediction happens on acceptance.
   always @(posedge clock) begin
      bit calm_now;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            track_header_byte(req_payload);
            void'(pending_beats.pop_front());
            beats_accepted++;
         end
         calm_now = (pending_beats.size() <= CALM_BEATS);
         calm <= calm_now;
         if (req_valid && req_stall) begin
            // stalled beat stays on the bus unchanged
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() == 0 ||
                      (pending_beats[0].drain && results_checked != results_predicted)) begin
            req_valid <= 1'b0;
         end else if (!calm_now && $urandom_range(0, 7) == 0) begin
            send_gap = int'($urandom_range(1, 11)) - 1;
            req_valid <= 1'b0;
         end else begin
            req_valid   <= 1'b1;
            req_payload <= pending_beats[0].beat;
         end
      end
   end

   // Monitor: checks each accepted result beat against the oldest
   // expectation and applies random backpressure.
   always @(posedge clock) begin
      chdp_pkg::rsp_type exp_hdr;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_headers.size() == 0) begin
               $display("%0t: unexpected result beat, actual %0h", $time, rsp_payload);
               error_count++;
            end else begin
               exp_hdr = expected_headers.pop_front();
               check_field("seq_num", 64'(exp_hdr.seq_num), 64'(rsp_payload.seq_num));
               check_field("cmd_code", 64'(exp_hdr.cmd_code), 64'(rsp_payload.cmd_code));
               check_field("operation", 64'(exp_hdr.operation),
                           64'(rsp_payload.operation));
               check_field("addressed", 64'(exp_hdr.addressed),
                           64'(rsp_payload.addressed));
               check_field("zone_id", 64'(exp_hdr.zone_id), 64'(rsp_payload.zone_id));
               check_field("status", 64'(exp_hdr.status), 64'(rsp_payload.status));
               status_tally[exp_hdr.status]++;
               results_checked <= results_checked + 1;
            end
         end
         if (stall_gap > 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_gap = int'($urandom_range(1, 11)) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: any long stretch without a beat on either side is a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, expected_headers.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int          kind;
      int          len;
      int          msg_count;
      bit          addr;
      logic [31:0] seq;
      logic [7:0]  flags;
      reset_shadow();

      // Directed: one-byte message, six-byte header that still records,
      // repeat of that number (duplicate with full header), and an
      // addressed message with the all-ones number.
      queue_message(32'h0, 8'h0, 8'h0, 48'h0, 1, 1'b0);
      queue_message(32'h0, 8'h0, 8'h0, 48'h0, 6, 1'b0);
      queue_message(32'h0, 8'hff, 8'h3f, 48'h0, 8, 1'b0);
      queue_message(chdp_pkg::SEQ_EMPTY, 8'h5a, 8'hc0, 48'hffff_ffff_ffff, 10, 1'b0);

      // Random: mostly well-formed messages, some repeating recent numbers
      // (both still in the ring and already evicted), plus truncated and
      // overlong ones, and the all-ones and zero numbers.
      msg_count = 0;
      while (pending_beats.size() < RANDOM_BEATS + 25) begin
         kind  = int'($urandom_range(0, 99));
         addr  = 1'($urandom_range(0, 1));
         seq   = $urandom;
         if ($urandom_range(0, 3) == 0)
            seq = seq_history[$urandom_range(0, seq_history.size() - 1)];
         if (kind < 55) begin
            len = addr ? 14 : 8;
         end else if (kind < 70) begin
            addr = 1'b1;
            len  = int'($urandom_range(8, 13));
         end else if (kind < 80) begin
            len = int'($urandom_range(1, 7));
         end else if (kind < 90) begin
            len = int'($urandom_range(15, 20));   // byte counter saturates
         end else begin
            seq = $urandom_range(0, 1) ? chdp_pkg::SEQ_EMPTY : 32'h0;
            len = addr ? 14 : 8;
         end
         flags    = 8'($urandom);
         flags[7] = addr;
         // pause for a full drain before the first and the 41st random message
         queue_message(seq, 8'($urandom), flags, {16'($urandom), 32'($urandom)}, len,
                       msg_count == 0 || msg_count == 40);
         msg_count++;
      end
      beats_total = pending_beats.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (beats_accepted == beats_total);
      wait (results_checked == results_predicted);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_headers.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_headers.size());
         error_count++;
      end

      $display("Sent %0d bytes in %0d messages; checked %0d results.",
               beats_total, msg_count + 4, results_checked);
      $display("Status mix: ok %0d, duplicate %0d, header short %0d, zone short %0d.",
               status_tally[chdp_pkg::STATUS_OK], status_tally[chdp_pkg::STATUS_DUPLICATE],
               status_tally[chdp_pkg::STATUS_HDR_SHORT],
               status_tally[chdp_pkg::STATUS_ZONE_SHORT]);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
